// ----- design/kseq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard scancode event queue package
// Shared types, widths, scancode constants and pointer helper.
// ----------------------------------------------------------------------------
package kseq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int KEY_W       = 16;
   localparam int STAMP_W     = 64;

   localparam logic [7:0] SC_EXTENDED = 8'hE0;
   localparam logic [7:0] SC_PAUSE    = 8'hE1;
   localparam int         SC_RELEASE_BIT = 7;

   typedef enum logic [1:0] {
      CMD_SCAN  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_TABLE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PFX_NORMAL = 2'd0,
      PFX_E0     = 2'd1,
      PFX_E1     = 2'd2
   } prefix_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         byte_in;
      logic [STAMP_W-1:0] stamp;
      logic               table_extended;
      logic [6:0]         table_index;
      logic [KEY_W-1:0]   table_keycode;
   } req_type;

   typedef struct packed {
      logic               event_valid;
      logic [KEY_W-1:0]   key_code;
      logic               key_pressed;
      logic [STAMP_W-1:0] event_stamp;
      logic               pushed;
      logic               dropped;
      logic               overflow_flushed;
      logic [FILL_W-1:0]  fill_count;
   } rsp_type;

   typedef struct packed {
      logic               pressed;
      logic [KEY_W-1:0]   key_code;
      logic [STAMP_W-1:0] stamp;
   } event_type;

   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] addr;
      logic [KEY_W-1:0]    data;
   } kmap_wr_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      event_type        data;
   } evq_wr_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ----- design/kseq_keymap.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keycode table
// 256 x 16 synchronous memory with per-entry valid bits; unwritten reads zero.
// ----------------------------------------------------------------------------
module kseq_keymap (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire kseq_pkg::kmap_wr_type              wr,
   input  wire logic [kseq_pkg::TABLE_AW-1:0]      rd_addr,
   output logic      [kseq_pkg::KEY_W-1:0]         rd_data
);

   logic [kseq_pkg::KEY_W-1:0] mem [kseq_pkg::TABLE_DEPTH];
   logic                       valid_ff [kseq_pkg::TABLE_DEPTH];
   logic [kseq_pkg::KEY_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kseq_pkg::TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ----- design/kseq_event_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event store
// Ring buffer memory of queued key events, one write and one read port.
// ----------------------------------------------------------------------------
module kseq_event_ram (
   input  wire logic                            clock,
   input  wire kseq_pkg::evq_wr_type            wr,
   input  wire logic [kseq_pkg::PTR_W-1:0]      rd_addr,
   output kseq_pkg::event_type                  rd_data
);

   kseq_pkg::event_type mem [kseq_pkg::QUEUE_DEPTH];
   kseq_pkg::event_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/keyboard_scancode_event_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard scancode event queue
// Set-1 scancode decoder with loadable keycode table and timestamped
// event FIFO.
//
//   channel   handshake              payload
//   request   start / busy           req_data  (req_type)
//   response  rsp_valid (strobe)     rsp_data  (rsp_type)
//   config    csr_wr_en              csr_wr_data (drop_when_full)
//
// Each request is handled in order: the accept cycle reads the keycode
// table and the event store at the read pointer, the ST_EXEC cycle after
// it applies the update and writes back; busy is high in ST_EXEC. The
// response strobes for one cycle right after, while the next request may
// already be taken. The receiver cannot stall. Synchronous reset clears
// the prefix, pointers, count and the table valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire kseq_pkg::req_type req_data,
   output logic                   rsp_valid,
   output kseq_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   kseq_pkg::state_type         state_ff, state_in;
   kseq_pkg::prefix_type        prefix_ff, prefix_in;
   kseq_pkg::req_type           req_ff;
   kseq_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        drop_when_full_ff;
   logic [kseq_pkg::PTR_W-1:0]  rptr_ff, rptr_in;
   logic [kseq_pkg::PTR_W-1:0]  wptr_ff, wptr_in;
   logic [kseq_pkg::FILL_W-1:0] count_ff, count_in;

   kseq_pkg::kmap_wr_type       kmap_wr;
   logic [kseq_pkg::TABLE_AW-1:0] kmap_rd_addr;
   logic [kseq_pkg::KEY_W-1:0]  kmap_rd_data;
   kseq_pkg::evq_wr_type        evq_wr;
   kseq_pkg::event_type         evq_rd_data;
   logic                        accept;

   assign busy   = (state_ff == kseq_pkg::ST_EXEC);
   assign accept = start && !busy;

   assign kmap_rd_addr = {prefix_ff == kseq_pkg::PFX_E0, req_data.byte_in[6:0]};

   kseq_keymap u_keymap (
      .clock   (clock),
      .reset   (reset),
      .wr      (kmap_wr),
      .rd_addr (kmap_rd_addr),
      .rd_data (kmap_rd_data)
   );

   kseq_event_ram u_event_ram (
      .clock   (clock),
      .wr      (evq_wr),
      .rd_addr (rptr_ff),
      .rd_data (evq_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= kseq_pkg::ST_IDLE;
         prefix_ff         <= kseq_pkg::PFX_NORMAL;
         rsp_valid_ff      <= 1'b0;
         drop_when_full_ff <= 1'b1;
         rptr_ff           <= '0;
         wptr_ff           <= '0;
         count_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            drop_when_full_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic                        is_key;
      logic [kseq_pkg::KEY_W-1:0]  kc;
      logic [kseq_pkg::PTR_W-1:0]  wbase;
      logic [kseq_pkg::PTR_W-1:0]  rbase;
      logic [kseq_pkg::FILL_W-1:0] cbase;
      logic                        full;

      state_in     = state_ff;
      prefix_in    = prefix_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      kmap_wr      = '0;
      evq_wr       = '0;
      is_key       = 1'b0;
      kc           = '0;
      wbase        = wptr_ff;
      rbase        = rptr_ff;
      cbase        = count_ff;
      full         = (count_ff == kseq_pkg::FILL_W'(kseq_pkg::QUEUE_DEPTH));

      unique case (state_ff)
         kseq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = kseq_pkg::ST_EXEC;
            end
         end
         kseq_pkg::ST_EXEC: begin
            state_in     = kseq_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (req_ff.cmd)
               kseq_pkg::CMD_SCAN: begin
                  if (req_ff.byte_in == kseq_pkg::SC_EXTENDED) begin
                     prefix_in = kseq_pkg::PFX_E0;
                  end else if (req_ff.byte_in == kseq_pkg::SC_PAUSE) begin
                     prefix_in = kseq_pkg::PFX_E1;
                  end else begin
                     prefix_in = kseq_pkg::PFX_NORMAL;
                     is_key    = 1'b1;
                  end
                  kc = (prefix_ff == kseq_pkg::PFX_E1) ? '0 : kmap_rd_data;
                  if (is_key && kc != '0) begin
                     if (full && drop_when_full_ff) begin
                        rsp_in.dropped = 1'b1;
                     end else begin
                        if (full) begin
                           rsp_in.overflow_flushed = 1'b1;
                           wbase = '0;
                           rbase = '0;
                           cbase = '0;
                        end
                        evq_wr.en            = 1'b1;
                        evq_wr.addr          = wbase;
                        evq_wr.data.key_code = kc;
                        evq_wr.data.pressed  =
                           !req_ff.byte_in[kseq_pkg::SC_RELEASE_BIT];
                        evq_wr.data.stamp    = req_ff.stamp;
                        wptr_in              = kseq_pkg::next_slot(wbase);
                        rptr_in              = rbase;
                        count_in             = cbase + 1'b1;
                        rsp_in.pushed        = 1'b1;
                     end
                  end
               end
               kseq_pkg::CMD_POP: begin
                  if (count_ff != '0) begin
                     rsp_in.event_valid = 1'b1;
                     rsp_in.key_code    = evq_rd_data.key_code;
                     rsp_in.key_pressed = evq_rd_data.pressed;
                     rsp_in.event_stamp = evq_rd_data.stamp;
                     rptr_in            = kseq_pkg::next_slot(rptr_ff);
                     count_in           = count_ff - 1'b1;
                  end
               end
               kseq_pkg::CMD_FLUSH: begin
                  rptr_in  = '0;
                  wptr_in  = '0;
                  count_in = '0;
               end
               kseq_pkg::CMD_TABLE: begin
                  kmap_wr.en   = 1'b1;
                  kmap_wr.addr = {req_ff.table_extended, req_ff.table_index};
                  kmap_wr.data = req_ff.table_keycode;
               end
               default: begin
               end
            endcase
            rsp_in.fill_count = count_in;
         end
         default: begin
            state_in = kseq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
